FILE: design/pssp_pkg.sv
package pssp_pkg;

  localparam int FracBits = 14;
  localparam int One      = 1 << FracBits;

  localparam logic [1:0] RegPtrX = 2'd0;
  localparam logic [1:0] RegPtrY = 2'd1;
  localparam logic [1:0] RegMode = 2'd2;

  localparam logic [1:0] ModeNone = 2'd0;
  localparam logic [1:0] ModePull = 2'd2;

  localparam longint QLimit    = ((longint'(1) << (2 * FracBits)) - 1) / 5;
  localparam int     DistOfs   = (One + 5000) / 10000;
  localparam int     ForceBase = (One * 45 + 50) / 100;
  localparam int     HalfCol   = (10 * One) / 2;

  typedef struct packed {
    logic               pull;
    logic               active;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [15:0] v1x;
    logic signed [15:0] v1y;
    logic signed [15:0] px;
    logic signed [15:0] py;
  } sq_tag_t;

  typedef struct packed {
    logic               active;
    logic               neg_x;
    logic               neg_y;
    logic signed [15:0] v1x;
    logic signed [15:0] v1y;
    logic signed [15:0] px;
    logic signed [15:0] py;
  } dv_tag_t;

  function automatic logic [10:0] div125(input logic [16:0] x);
    logic [34:0] p;
    p = 35'(x) * 35'(134218);
    return p[34:24];
  endfunction

  function automatic logic [15:0] div25(input logic [19:0] x);
    logic [40:0] p;
    p = 41'(x) * 41'(1342178);
    return p[40:25];
  endfunction

  function automatic logic [9:0] div5(input logic [11:0] x);
    logic [24:0] p;
    p = 25'(x) * 25'(6554);
    return p[24:15];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [17:0] x);
    logic signed [15:0] r;
    if (x > 18'sd32767) begin
      r = 16'sh7fff;
    end else if (x < -18'sd32768) begin
      r = -16'sh8000;
    end else begin
      r = x[15:0];
    end
    return r;
  endfunction

  function automatic logic [7:0] clamp8(input logic [9:0] x);
    return (x > 10'd255) ? 8'd255 : x[7:0];
  endfunction

endpackage

FILE: design/pssp_sqrt.sv
module pssp_sqrt import pssp_pkg::*; #(
  parameter int TagW = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [25:0]       rad_i,
  input  logic [TagW-1:0]   tag_i,
  output logic              valid_o,
  output logic [12:0]       root_o,
  output logic [TagW-1:0]   tag_o
);

  localparam int Steps = 13;
  localparam int RadW  = 2 * Steps;

  logic            vld  [Steps+1];
  logic [RadW-1:0] rad  [Steps+1];
  logic [15:0]     rem  [Steps+1];
  logic [12:0]     root [Steps+1];
  logic [TagW-1:0] tag  [Steps+1];

  assign vld[0]  = valid_i;
  assign rad[0]  = rad_i;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign tag[0]  = tag_i;

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic [15:0] rsh;
    logic [15:0] trial;
    logic [15:0] rem_d;
    logic [12:0] root_d;

    always_comb begin
      rsh   = {rem[k][13:0], rad[k][RadW-1 -: 2]};
      trial = {1'b0, root[k], 2'b01};
      if (rsh >= trial) begin
        rem_d  = rsh - trial;
        root_d = {root[k][11:0], 1'b1};
      end else begin
        rem_d  = rsh;
        root_d = {root[k][11:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rad[k+1]  <= {rad[k][RadW-3:0], 2'b00};
      rem[k+1]  <= rem_d;
      root[k+1] <= root_d;
      tag[k+1]  <= tag[k];
    end
  end

  assign valid_o = vld[Steps];
  assign root_o  = root[Steps];
  assign tag_o   = tag[Steps];

endmodule

FILE: design/pssp_div.sv
module pssp_div import pssp_pkg::*; #(
  parameter int TagW = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [22:0]       num_a_i,
  input  logic [22:0]       num_b_i,
  input  logic [13:0]       den_i,
  input  logic [TagW-1:0]   tag_i,
  output logic              valid_o,
  output logic [9:0]        quot_a_o,
  output logic [9:0]        quot_b_o,
  output logic [TagW-1:0]   tag_o
);

  localparam int Steps = 10;
  localparam int NumW  = 23;

  logic            vld [Steps+1];
  logic [NumW-1:0] ra  [Steps+1];
  logic [NumW-1:0] rb  [Steps+1];
  logic [Steps-1:0] qa [Steps+1];
  logic [Steps-1:0] qb [Steps+1];
  logic [13:0]     den [Steps+1];
  logic [TagW-1:0] tag [Steps+1];

  assign vld[0] = valid_i;
  assign ra[0]  = num_a_i;
  assign rb[0]  = num_b_i;
  assign qa[0]  = '0;
  assign qb[0]  = '0;
  assign den[0] = den_i;
  assign tag[0] = tag_i;

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic [NumW-1:0] dsh;
    logic            ba;
    logic            bb;

    always_comb begin
      dsh = NumW'(den[k]) << (Steps - 1 - k);
      ba  = (ra[k] >= dsh);
      bb  = (rb[k] >= dsh);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      ra[k+1]  <= ba ? ra[k] - dsh : ra[k];
      rb[k+1]  <= bb ? rb[k] - dsh : rb[k];
      qa[k+1]  <= {qa[k][Steps-2:0], ba};
      qb[k+1]  <= {qb[k][Steps-2:0], bb};
      den[k+1] <= den[k];
      tag[k+1] <= tag[k];
    end
  end

  assign valid_o  = vld[Steps];
  assign quot_a_o = qa[Steps];
  assign quot_b_o = qb[Steps];
  assign tag_o    = tag[Steps];

endmodule

FILE: design/particle_spring_pointer_step_unit.sv
// Particle update: spring toward home, pointer push or pull, damping, color.
// Input channel: drive start_i with pos/vel/home for one cycle per particle;
// busy_o stays low, so a particle is taken in every cycle start_i is high.
// Configuration channel: cfg_valid_i/cfg_ready_o with cfg_index_i (0 pointer
// x, 1 pointer y, 2 interaction mode) and cfg_data_i; cfg_ready_o is always
// high. Write it only while no particle is in flight.
// Result channel: done_o is high for one cycle together with the new
// position, velocity and color of one particle, in input order.
// Throughput: one particle per cycle, every cycle. The depth is set
// by the 13-step square root and the 10-step divider for the pointer force,
// each one step per pipeline stage.
// Reset clears the pointer registers, the mode and every stage valid bit;
// particles in flight are dropped. The receiver cannot stall the pipeline.
module particle_spring_pointer_step_unit import pssp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [15:0] vel_x_i,
  input  logic signed [15:0] vel_y_i,
  input  logic signed [15:0] home_x_i,
  input  logic signed [15:0] home_y_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output logic               done_o,
  output logic signed [15:0] new_pos_x_o,
  output logic signed [15:0] new_pos_y_o,
  output logic signed [15:0] new_vel_x_o,
  output logic signed [15:0] new_vel_y_o,
  output logic [7:0]         red_o,
  output logic [7:0]         green_o,
  output logic [7:0]         blue_o
);

  logic signed [15:0] ptr_x_q, ptr_y_q;
  logic [1:0]         mode_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_x_q <= '0;
      ptr_y_q <= '0;
      mode_q  <= ModeNone;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegPtrX: ptr_x_q <= cfg_data_i;
        RegPtrY: ptr_y_q <= cfg_data_i;
        RegMode: mode_q  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // stage 1: spring offset and pointer offset
  logic signed [16:0] dhx, dhy;
  logic [16:0]        adhx, adhy;
  logic [19:0]        sprx, spry;
  logic               s1_vld_q;
  logic signed [15:0] s1_px_q, s1_py_q, s1_vx_q, s1_vy_q;
  logic [16:0]        s1_ax_q, s1_ay_q;
  logic               s1_nx_q, s1_ny_q;
  logic signed [16:0] s1_dx_q, s1_dy_q;

  always_comb begin
    dhx  = 17'(home_x_i) - 17'(pos_x_i);
    dhy  = 17'(home_y_i) - 17'(pos_y_i);
    adhx = dhx[16] ? 17'(-dhx) : 17'(dhx);
    adhy = dhy[16] ? 17'(-dhy) : 17'(dhy);
    sprx = 20'(20'(adhx) * 20'd15 + 20'd500);
    spry = 20'(20'(adhy) * 20'd15 + 20'd500);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_px_q <= pos_x_i;
    s1_py_q <= pos_y_i;
    s1_vx_q <= vel_x_i;
    s1_vy_q <= vel_y_i;
    s1_ax_q <= sprx[19:3];
    s1_ay_q <= spry[19:3];
    s1_nx_q <= dhx[16];
    s1_ny_q <= dhy[16];
    s1_dx_q <= 17'(pos_x_i) - 17'(ptr_x_q);
    s1_dy_q <= 17'(pos_y_i) - 17'(ptr_y_q);
  end

  // stage 2: spring quotient and squares
  logic               s2_vld_q;
  logic signed [15:0] s2_px_q, s2_py_q, s2_vx_q, s2_vy_q;
  logic [10:0]        s2_qx_q, s2_qy_q;
  logic               s2_nx_q, s2_ny_q;
  logic signed [16:0] s2_dx_q, s2_dy_q;
  logic [32:0]        s2_sqx_q, s2_sqy_q;
  logic signed [33:0] sqx, sqy;

  always_comb begin
    sqx = 34'(s1_dx_q) * 34'(s1_dx_q);
    sqy = 34'(s1_dy_q) * 34'(s1_dy_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_px_q  <= s1_px_q;
    s2_py_q  <= s1_py_q;
    s2_vx_q  <= s1_vx_q;
    s2_vy_q  <= s1_vy_q;
    s2_qx_q  <= div125(s1_ax_q);
    s2_qy_q  <= div125(s1_ay_q);
    s2_nx_q  <= s1_nx_q;
    s2_ny_q  <= s1_ny_q;
    s2_dx_q  <= s1_dx_q;
    s2_dy_q  <= s1_dy_q;
    s2_sqx_q <= sqx[32:0];
    s2_sqy_q <= sqy[32:0];
  end

  // stage 3: spring velocity, squared distance, activity
  logic signed [17:0] spx, spy;
  logic [33:0]        qsum;
  sq_tag_t            s3_tag_d, s3_tag_q;
  logic               s3_vld_q;
  logic [25:0]        s3_rad_q;

  always_comb begin
    spx             = s2_nx_q ? -18'(s2_qx_q) : 18'(s2_qx_q);
    spy             = s2_ny_q ? -18'(s2_qy_q) : 18'(s2_qy_q);
    qsum            = 34'(s2_sqx_q) + 34'(s2_sqy_q);
    s3_tag_d.pull   = (mode_q >= ModePull);
    s3_tag_d.active = (mode_q != ModeNone) && (qsum <= 34'(QLimit));
    s3_tag_d.dx     = s2_dx_q;
    s3_tag_d.dy     = s2_dy_q;
    s3_tag_d.v1x    = sat16(18'(s2_vx_q) + spx);
    s3_tag_d.v1y    = sat16(18'(s2_vy_q) + spy);
    s3_tag_d.px     = s2_px_q;
    s3_tag_d.py     = s2_py_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_tag_q <= s3_tag_d;
    s3_rad_q <= qsum[25:0];
  end

  logic                       sq_vld;
  logic [12:0]                sq_root;
  logic [$bits(sq_tag_t)-1:0] sq_tag_raw;
  sq_tag_t                    sq_tag;

  pssp_sqrt #(.TagW($bits(sq_tag_t))) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s3_vld_q),
    .rad_i   (s3_rad_q),
    .tag_i   (s3_tag_q),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .tag_o   (sq_tag_raw)
  );

  assign sq_tag = sq_tag_raw;

  // force: distance, then magnitude
  logic [13:0] rdist, fn;
  logic [16:0] ft;
  logic        f1_vld_q, f2_vld_q;
  sq_tag_t     f1_tag_q, f2_tag_q;
  logic [13:0] f1_dist_q, f2_dist_q;
  logic [14:0] f1_t_q;
  logic [15:0] f2_force_q;

  always_comb begin
    rdist = 14'(sq_root) + 14'(DistOfs);
    fn    = 14'(ForceBase) - rdist;
    ft    = 17'(17'(fn[12:0]) * 17'd12 + 17'd50);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
      f2_vld_q <= 1'b0;
    end else begin
      f1_vld_q <= sq_vld;
      f2_vld_q <= f1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f1_tag_q   <= sq_tag;
    f1_dist_q  <= rdist;
    f1_t_q     <= ft[16:2];
    f2_tag_q   <= f1_tag_q;
    f2_dist_q  <= f1_dist_q;
    f2_force_q <= div25(20'(f1_t_q));
  end

  // stage F3: numerators for the radial split
  logic [16:0] adx, ady;
  logic        f3_vld_q;
  logic [22:0] f3_na_q, f3_nb_q;
  logic [13:0] f3_dist_q;
  dv_tag_t     f3_tag_d, f3_tag_q;

  always_comb begin
    adx             = f2_tag_q.dx[16] ? 17'(-f2_tag_q.dx) : 17'(f2_tag_q.dx);
    ady             = f2_tag_q.dy[16] ? 17'(-f2_tag_q.dy) : 17'(f2_tag_q.dy);
    f3_tag_d.active = f2_tag_q.active;
    f3_tag_d.neg_x  = f2_tag_q.dx[16] ^ f2_tag_q.pull;
    f3_tag_d.neg_y  = f2_tag_q.dy[16] ^ f2_tag_q.pull;
    f3_tag_d.v1x    = f2_tag_q.v1x;
    f3_tag_d.v1y    = f2_tag_q.v1y;
    f3_tag_d.px     = f2_tag_q.px;
    f3_tag_d.py     = f2_tag_q.py;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f3_vld_q <= 1'b0;
    end else begin
      f3_vld_q <= f2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f3_na_q   <= 23'(adx[12:0]) * 23'(f2_force_q[9:0]) + 23'(f2_dist_q[13:1]);
    f3_nb_q   <= 23'(ady[12:0]) * 23'(f2_force_q[9:0]) + 23'(f2_dist_q[13:1]);
    f3_dist_q <= f2_dist_q;
    f3_tag_q  <= f3_tag_d;
  end

  logic                       dv_vld;
  logic [9:0]                 dv_qx, dv_qy;
  logic [$bits(dv_tag_t)-1:0] dv_tag_raw;
  dv_tag_t                    dv_tag;

  pssp_div #(.TagW($bits(dv_tag_t))) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (f3_vld_q),
    .num_a_i  (f3_na_q),
    .num_b_i  (f3_nb_q),
    .den_i    (f3_dist_q),
    .tag_i    (f3_tag_q),
    .valid_o  (dv_vld),
    .quot_a_o (dv_qx),
    .quot_b_o (dv_qy),
    .tag_o    (dv_tag_raw)
  );

  assign dv_tag = dv_tag_raw;

  // stage V2: add pointer force
  logic signed [17:0] fx, fy;
  logic               v2_vld_q;
  logic signed [15:0] v2_vx_q, v2_vy_q, v2_px_q, v2_py_q;

  always_comb begin
    fx = dv_tag.neg_x ? -18'(dv_qx) : 18'(dv_qx);
    fy = dv_tag.neg_y ? -18'(dv_qy) : 18'(dv_qy);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_vld_q <= 1'b0;
    end else begin
      v2_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    v2_vx_q <= dv_tag.active ? sat16(18'(dv_tag.v1x) + fx) : dv_tag.v1x;
    v2_vy_q <= dv_tag.active ? sat16(18'(dv_tag.v1y) + fy) : dv_tag.v1y;
    v2_px_q <= dv_tag.px;
    v2_py_q <= dv_tag.py;
  end

  // stages D1, D2: damping
  logic signed [16:0] v2ex, v2ey;
  logic [16:0]        avx, avy;
  logic [21:0]        dtx, dty;
  logic               d1_vld_q, d2_vld_q;
  logic [19:0]        d1_tx_q, d1_ty_q;
  logic               d1_nx_q, d1_ny_q;
  logic signed [15:0] d1_px_q, d1_py_q, d2_px_q, d2_py_q;
  logic [15:0]        nvmx, nvmy;
  logic signed [15:0] d2_vx_q, d2_vy_q;

  always_comb begin
    v2ex = 17'(v2_vx_q);
    v2ey = 17'(v2_vy_q);
    avx  = v2ex[16] ? 17'(-v2ex) : 17'(v2ex);
    avy  = v2ey[16] ? 17'(-v2ey) : 17'(v2ey);
    dtx  = 22'(22'(avx) * 22'd92 + 22'd50);
    dty  = 22'(22'(avy) * 22'd92 + 22'd50);
    nvmx = div25(d1_tx_q);
    nvmy = div25(d1_ty_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_vld_q <= 1'b0;
      d2_vld_q <= 1'b0;
    end else begin
      d1_vld_q <= v2_vld_q;
      d2_vld_q <= d1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d1_tx_q <= dtx[21:2];
    d1_ty_q <= dty[21:2];
    d1_nx_q <= v2ex[16];
    d1_ny_q <= v2ey[16];
    d1_px_q <= v2_px_q;
    d1_py_q <= v2_py_q;
    d2_vx_q <= d1_nx_q ? 16'(-nvmx) : nvmx;
    d2_vy_q <= d1_ny_q ? 16'(-nvmy) : nvmy;
    d2_px_q <= d1_px_q;
    d2_py_q <= d1_py_q;
  end

  // stage P: position and speed
  logic [15:0]        ax2, ay2;
  logic [16:0]        spd;
  logic               p_vld_q;
  logic signed [15:0] p_nx_q, p_ny_q, p_vx_q, p_vy_q;
  logic [11:0]        p_sr_q;

  always_comb begin
    ax2 = d2_vx_q[15] ? 16'(-d2_vx_q) : 16'(d2_vx_q);
    ay2 = d2_vy_q[15] ? 16'(-d2_vy_q) : 16'(d2_vy_q);
    spd = 17'(ax2) + 17'(ay2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else begin
      p_vld_q <= d2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p_nx_q <= sat16(18'(d2_px_q) + 18'(d2_vx_q));
    p_ny_q <= sat16(18'(d2_py_q) + 18'(d2_vy_q));
    p_vx_q <= d2_vx_q;
    p_vy_q <= d2_vy_q;
    p_sr_q <= (spd > 17'd4095) ? 12'd4095 : spd[11:0];
  end

  // stages C1, C2: color
  logic [26:0]        rnum, gnum, bnum;
  logic signed [18:0] bsum;
  logic               c1_vld_q;
  logic [11:0]        c1_r_q, c1_g_q, c1_b_q;
  logic signed [15:0] c1_nx_q, c1_ny_q, c1_vx_q, c1_vy_q;
  logic               done_q;

  always_comb begin
    rnum = 27'(255) * (27'(One) + 27'(p_sr_q) * 27'd100) + 27'(HalfCol);
    gnum = 27'(255) * (27'(3 * One) + 27'(p_sr_q) * 27'd50) + 27'(HalfCol);
    bsum = 19'(8 * One) + (19'(p_nx_q) <<< 1);
    bnum = 27'(bsum[17:0]) * 27'(255) + 27'(HalfCol);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      c1_vld_q <= p_vld_q;
      done_q   <= c1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c1_r_q      <= rnum[26:15];
    c1_g_q      <= gnum[26:15];
    c1_b_q      <= bnum[26:15];
    c1_nx_q     <= p_nx_q;
    c1_ny_q     <= p_ny_q;
    c1_vx_q     <= p_vx_q;
    c1_vy_q     <= p_vy_q;
    red_o       <= clamp8(div5(c1_r_q));
    green_o     <= clamp8(div5(c1_g_q));
    blue_o      <= clamp8(div5(c1_b_q));
    new_pos_x_o <= c1_nx_q;
    new_pos_y_o <= c1_ny_q;
    new_vel_x_o <= c1_vx_q;
    new_vel_y_o <= c1_vy_q;
  end

  assign done_o = done_q;

`ifndef SYNTH
  a_force_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_vld && dv_tag.active |-> dv_qx <= 10'd886 && dv_qy <= 10'd886)
    else $error("pointer force quotient out of range");

  a_rest_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && new_vel_x_o == 16'sd0 && new_vel_y_o == 16'sd0
      |-> red_o == 8'd26 && green_o == 8'd77)
    else $error("color of particle at rest is wrong");

  a_color_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> red_o >= 8'd26 && green_o >= 8'd77 && blue_o >= 8'd102)
    else $error("color below its floor");

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(p_vld_q, 2))
    else $error("result strobe without a particle in flight");
`endif

endmodule

FILE: tb/particle_spring_pointer_step_unit_tb.sv
module particle_spring_pointer_step_unit_tb;
  import pssp_pkg::*;

  localparam logic [1:0] RegSpare = 2'd3;
  localparam logic [1:0] ModePush = 2'd1;
  localparam logic [1:0] ModeBoth = 2'd3;
  localparam int         DrainCycles = 40;
  localparam int         CycleLimit = 300000;

  typedef struct {
    bit                 is_cfg;
    logic [1:0]         idx;
    logic [15:0]        data;
    int                 idle_pct;
    logic signed [15:0] px, py, vx, vy, hx, hy;
  } pending_t;

  typedef struct {
    logic signed [15:0] pos_x, pos_y, vel_x, vel_y;
    logic [7:0]         red, green, blue;
  } particle_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic signed [15:0] pos_x_i = '0, pos_y_i = '0, vel_x_i = '0, vel_y_i = '0;
  logic signed [15:0] home_x_i = '0, home_y_i = '0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = '0;
  logic [15:0]        cfg_data_i = '0;
  logic               done_o;
  logic signed [15:0] new_pos_x_o, new_pos_y_o, new_vel_x_o, new_vel_y_o;
  logic [7:0]         red_o, green_o, blue_o;

  pending_t  pending_q[$];
  particle_t particle_q[$];
  longint    ptr_x = 0, ptr_y = 0;
  logic [1:0] mode = ModeNone;
  int        errors = 0;
  int        cycles = 0;

  particle_spring_pointer_step_unit i_dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic longint rnd_div(longint n, longint d);
    return (n >= 0) ? (n + d / 2) / d : -((-n + d / 2) / d);
  endfunction

  function automatic longint sat_16(longint v);
    return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
  endfunction

  function automatic longint clamp_8(longint v);
    return (v > 255) ? 255 : ((v < 0) ? 0 : v);
  endfunction

  function automatic longint int_sqrt(longint v);
    longint r;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      if ((r | (longint'(1) << b)) * (r | (longint'(1) << b)) <= v) r |= longint'(1) << b;
    end
    return r;
  endfunction

  function automatic particle_t step_particle(pending_t p);
    particle_t r;
    longint unit_one, vx1, vy1, dx, dy, q, dst, frc, nx, ny, s;
    unit_one = longint'(1) << FracBits;
    vx1 = sat_16(longint'(p.vx) + rnd_div((longint'(p.hx) - p.px) * 15, 1000));
    vy1 = sat_16(longint'(p.vy) + rnd_div((longint'(p.hy) - p.py) * 15, 1000));
    if (mode != ModeNone) begin
      dx = longint'(p.px) - ptr_x;
      dy = longint'(p.py) - ptr_y;
      q = dx * dx + dy * dy;
      if (q * 5 < (longint'(1) << (2 * FracBits))) begin
        dst = int_sqrt(q) + rnd_div(unit_one, 10000);
        if (dst < 1) dst = 1;
        frc = rnd_div((rnd_div(unit_one * 45, 100) - dst) * 12, 100);
        if (mode >= ModePull) frc = -frc;
        vx1 = sat_16(vx1 + rnd_div(dx * frc, dst));
        vy1 = sat_16(vy1 + rnd_div(dy * frc, dst));
      end
    end
    vx1 = rnd_div(vx1 * 92, 100);
    vy1 = rnd_div(vy1 * 92, 100);
    nx = sat_16(longint'(p.px) + vx1);
    ny = sat_16(longint'(p.py) + vy1);
    s = (vx1 < 0 ? -vx1 : vx1) + (vy1 < 0 ? -vy1 : vy1);
    r.pos_x = nx[15:0];
    r.pos_y = ny[15:0];
    r.vel_x = vx1[15:0];
    r.vel_y = vy1[15:0];
    r.red   = 8'(clamp_8(rnd_div(255 * (unit_one + 100 * s), 10 * unit_one)));
    r.green = 8'(clamp_8(rnd_div(255 * (3 * unit_one + 50 * s), 10 * unit_one)));
    r.blue  = 8'(clamp_8(rnd_div(255 * (8 * unit_one + 2 * nx), 10 * unit_one)));
    return r;
  endfunction

  always @(posedge clk_i) begin
    pending_t  cur, nxt;
    logic      n_start, n_cfg;
    n_start = start_i;
    n_cfg = cfg_valid_i;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        cur.px = pos_x_i; cur.py = pos_y_i; cur.vx = vel_x_i; cur.vy = vel_y_i;
        cur.hx = home_x_i; cur.hy = home_y_i;
        particle_q.push_back(step_particle(cur));
        n_start = 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == RegPtrX) ptr_x = longint'($signed(cfg_data_i));
        else if (cfg_index_i == RegPtrY) ptr_y = longint'($signed(cfg_data_i));
        else if (cfg_index_i == RegMode) mode = cfg_data_i[1:0];
        n_cfg = 1'b0;
      end
      if (!n_start && !n_cfg && pending_q.size() > 0) begin
        nxt = pending_q[0];
        if ($urandom_range(0, 99) >= nxt.idle_pct) begin
          if (nxt.is_cfg) begin
            if (particle_q.size() == 0 && !start_i) begin
              cfg_index_i <= nxt.idx;
              cfg_data_i <= nxt.data;
              n_cfg = 1'b1;
              void'(pending_q.pop_front());
            end
          end else begin
            pos_x_i <= nxt.px; pos_y_i <= nxt.py; vel_x_i <= nxt.vx;
            vel_y_i <= nxt.vy; home_x_i <= nxt.hx; home_y_i <= nxt.hy;
            n_start = 1'b1;
            void'(pending_q.pop_front());
          end
        end
      end
    end
    start_i <= n_start;
    cfg_valid_i <= n_cfg;
  end

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    particle_t e;
    if (rst_ni && done_o) begin
      if (particle_q.size() == 0) begin
        $error("result with no transaction outstanding");
        errors++;
      end else begin
        e = particle_q.pop_front();
        check_field("new_pos_x", e.pos_x, new_pos_x_o);
        check_field("new_pos_y", e.pos_y, new_pos_y_o);
        check_field("new_vel_x", e.vel_x, new_vel_x_o);
        check_field("new_vel_y", e.vel_y, new_vel_y_o);
        check_field("red", e.red, red_o);
        check_field("green", e.green, green_o);
        check_field("blue", e.blue, blue_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[particle_spring_pointer_step_unit] ERROR");
      $finish;
    end
  end

  task automatic add_cfg(logic [1:0] idx, logic [15:0] data, int pct);
    pending_t p;
    p = '{default: '0};
    p.is_cfg = 1'b1; p.idx = idx; p.data = data; p.idle_pct = pct;
    pending_q.push_back(p);
  endtask

  task automatic add_item(int px, int py, int vx, int vy, int hx, int hy, int pct);
    pending_t p;
    p = '{default: '0};
    p.idle_pct = pct;
    p.px = 16'(px); p.py = 16'(py); p.vx = 16'(vx);
    p.vy = 16'(vy); p.hx = 16'(hx); p.hy = 16'(hy);
    pending_q.push_back(p);
  endtask

  function automatic int rand16();
    return int'($signed(16'($urandom())));
  endfunction

  initial begin
    int pcts[4];
    int cx, cy, pct;
    pcts = '{0, 84, 0, 12};

    // directed: extremes, every mode, pointer on the particle, spare index
    add_item(0, 0, 0, 0, 0, 0, 0);
    add_item(32767, 32767, 32767, 32767, -32768, -32768, 0);
    add_item(-32768, -32768, -32768, -32768, 32767, 32767, 0);
    add_item(32767, -32768, 32767, -32768, 32767, -32768, 0);
    add_cfg(RegSpare, 16'hffff, 0);
    add_cfg(RegMode, 16'hfff5, 0);
    add_item(0, 0, 0, 0, 0, 0, 0);
    add_item(100, -50, 0, 0, 0, 0, 0);
    add_item(7000, 0, 32767, 0, 7000, 0, 0);
    add_cfg(RegMode, {14'h0, ModePull}, 0);
    add_item(100, -50, 0, 0, 0, 0, 0);
    add_item(0, 7000, 0, -32768, 0, 0, 0);
    add_cfg(RegPtrX, 16'h7fff, 0);
    add_cfg(RegPtrY, 16'h8000, 0);
    add_cfg(RegMode, {14'h0, ModeBoth}, 0);
    add_item(32767, -32768, 0, 0, 32767, -32768, 0);
    add_item(32000, -32000, 100, -100, 0, 0, 0);
    add_cfg(RegMode, {14'h0, ModePush}, 0);
    add_item(32767, -32768, 1, 1, 0, 0, 0);
    add_item(30000, -30000, 0, 0, 0, 0, 0);
    add_item(32767, -25500, 32767, 32767, 32767, 32767, 0);

    for (int ph = 0; ph < 4; ph++) begin
      pct = pcts[ph];
      for (int n = 0; n < 360; n++) begin
        if (n % 60 == 0) begin
          cx = ($urandom_range(0, 7) == 0) ? (($urandom_range(0, 1) != 0) ? 32767 : -32768)
                                          : rand16();
          cy = rand16();
          add_cfg(RegPtrX, 16'(cx), pct);
          add_cfg(RegPtrY, 16'(cy), pct);
          add_cfg(RegMode, 16'($urandom()), pct);
        end
        if ($urandom_range(0, 2) != 0)
          add_item(cx + $urandom_range(0, 14000) - 7000, cy + $urandom_range(0, 14000) - 7000,
                   rand16() >>> $urandom_range(0, 15), rand16() >>> $urandom_range(0, 15),
                   rand16(), rand16(), pct);
        else
          add_item(rand16(), rand16(), rand16(), rand16(), rand16(), rand16(), pct);
      end
    end
    add_cfg(RegMode, {14'h0, ModeNone}, 0);
    add_item(rand16(), rand16(), rand16(), rand16(), rand16(), rand16(), 0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_q.size() == 0 && !start_i && !cfg_valid_i && particle_q.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0 && particle_q.size() == 0) begin
      $display("[particle_spring_pointer_step_unit] OK");
    end else begin
      $display("[particle_spring_pointer_step_unit] ERROR");
    end
    $finish;
  end

endmodule
